### sv/assert_macros.svh
// Assertion macros shared by the RTL of the bounded double-ended queue.
// No dependencies; the assertions compile to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that must also hold while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/bdeq_pkg.sv
// Shared types and constants of the bounded double-ended queue.
// No dependencies; used by bdeq_cell and bounded_double_ended_queue.
package bdeq_pkg;

   localparam int WORD_W       = 32;
   localparam int ACTION_W     = 3;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_FRONT = 3'd0,
      ACT_INSERT_REAR  = 3'd1,
      ACT_DELETE_FRONT = 3'd2,
      ACT_DELETE_REAR  = 3'd3,
      ACT_PEEK_FRONT   = 3'd4,
      ACT_PEEK_REAR    = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // What every cell of the chain does in this cycle.
   typedef enum logic [2:0] {
      CELL_HOLD       = 3'd0,
      CELL_PUSH_FRONT = 3'd1,
      CELL_PUSH_REAR  = 3'd2,
      CELL_POP_FRONT  = 3'd3,
      CELL_POP_REAR   = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [WORD_W-1:0] value;
   } cell_ctrl_type;

endpackage

### sv/bdeq_cell.sv
// One storage cell of the queue chain: a word, its valid bit and a rear tap.
// Depends on bdeq_pkg.
module bdeq_cell import bdeq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [WORD_W-1:0] prev_data,
   input  logic              prev_valid,
   input  logic [WORD_W-1:0] next_data,
   input  logic              next_valid,
   input  logic [WORD_W-1:0] next_tap,
   output logic [WORD_W-1:0] data,
   output logic              valid,
   output logic [WORD_W-1:0] tap
);

   logic [WORD_W-1:0] data_ff, data_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] tap_ff, tap_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_PUSH_FRONT: begin
            data_in  = prev_data;
            valid_in = prev_valid;
         end
         CELL_PUSH_REAR: begin
            // only the first empty cell takes the word
            if (!valid_ff && prev_valid) begin
               data_in  = ctrl.value;
               valid_in = 1'b1;
            end
         end
         CELL_POP_FRONT: begin
            data_in  = next_data;
            valid_in = next_valid;
         end
         CELL_POP_REAR: begin
            valid_in = valid_ff & next_valid;
         end
         default: begin
         end
      endcase
   end

   // rear word ripples toward the front, one cell per cycle
   assign tap_in = next_valid ? next_tap : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign tap   = tap_ff;

endmodule

### sv/bounded_double_ended_queue.sv
// Bounded double-ended queue built as a chain of CAPACITY cells, front at cell 0.
// The result is registered and appears in the cycle after the request transfer.
// A peek or refused action leaves the next request unblocked unless the response is stalled;
// an insert or delete blocks the next request while the rear tap ripples down the chain.
// Reset (synchronous, active high) empties the queue; stored words are not cleared.
module bounded_double_ended_queue import bdeq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_peek_value,
   output logic [CNT_W-1:0]         rsp_occupancy
);

   `include "assert_macros.svh"

   localparam int SETTLE_W = $clog2(CAPACITY + 1);

   logic [WORD_W-1:0] data_vec [CAPACITY];
   logic [WORD_W-1:0] tap_vec  [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [WORD_W-1:0]   peek_ff, peek_in;
   logic [CNT_W-1:0]    occ_ff;

   logic          req_accept;
   logic          full, empty;
   logic          changes;
   cell_op_type   op;
   cell_ctrl_type ctrl;

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign req_stall  = (settle_ff != '0) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      status_in = ST_DONE;
      peek_in   = '0;
      count_in  = count_ff;
      op        = CELL_HOLD;
      unique case (action_type'(req_action))
         ACT_INSERT_FRONT, ACT_INSERT_REAR: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = (action_type'(req_action) == ACT_INSERT_FRONT) ?
                          CELL_PUSH_FRONT : CELL_PUSH_REAR;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_DELETE_FRONT, ACT_DELETE_REAR: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               op       = (action_type'(req_action) == ACT_DELETE_FRONT) ?
                          CELL_POP_FRONT : CELL_POP_REAR;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_PEEK_FRONT: begin
            if (empty) status_in = ST_EMPTY;
            else       peek_in   = data_vec[0];
         end
         ACT_PEEK_REAR: begin
            if (empty) status_in = ST_EMPTY;
            else       peek_in   = tap_vec[0];
         end
         default: begin
         end
      endcase
   end

   assign changes = (op != CELL_HOLD);
   assign ctrl    = '{op: (req_accept ? op : CELL_HOLD), value: req_value};

   always_comb begin
      settle_in = settle_ff;
      if (req_accept && changes) begin
         settle_in = SETTLE_W'(CAPACITY);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)     rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) count_ff <= count_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         status_ff <= status_in;
         peek_ff   <= peek_in;
         occ_ff    <= count_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] prev_data, next_data, next_tap;
      logic              prev_valid, next_valid;
      if (i == 0) begin : g_first
         assign prev_data  = req_value;
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_data  = data_vec[i-1];
         assign prev_valid = valid_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_data  = '0;
         assign next_valid = 1'b0;
         assign next_tap   = '0;
      end else begin : g_inner
         assign next_data  = data_vec[i+1];
         assign next_valid = valid_vec[i+1];
         assign next_tap   = tap_vec[i+1];
      end
      bdeq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_data  (prev_data),
         .prev_valid (prev_valid),
         .next_data  (next_data),
         .next_valid (next_valid),
         .next_tap   (next_tap),
         .data       (data_vec[i]),
         .valid      (valid_vec[i]),
         .tap        (tap_vec[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_peek_value = $signed(peek_ff);
   assign rsp_occupancy  = occ_ff;

   // occupied cells always form an unbroken run from the front
   `ASSERT_CLK(a_valid_run, clock, reset, ((valid_vec >> 1) & ~valid_vec) == '0, "valid gap in chain")
   `ASSERT_CLK(a_count_match, clock, reset, $countones(valid_vec) == int'(count_ff), "count mismatch")
   `ASSERT_CLK(a_settle_start, clock, reset, (req_accept && changes) |=> (settle_ff != '0), "no settle")
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (count_ff == '0 && !rsp_valid_ff), "not empty after reset")

endmodule
